// ===== sv/lam_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lam_pkg
// Shared widths, types and latency helpers for the look-at view matrix block.
// ----------------------------------------------------------------------------
package lam_pkg;

  // window of the scaled magnitudes, square sum and root widths
  localparam int MW = 30;
  localparam int LW = 31;
  localparam int SW = 2 * LW;
  localparam int RW = LW + 3;

  localparam int DOT_LAT = 4;

  localparam logic signed [31:0] I32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] I32_MIN = 32'sh80000000;

  typedef struct packed {
    logic valid;
    logic nz;
  } norm_stat_t;

  // magnitude, encode, align, square, sum, root steps, divide setup,
  // divide steps, sign
  function automatic int norm_lat(input int f);
    return f + LW + 8;
  endfunction

  function automatic int total_lat(input int f);
    return 2 * norm_lat(f) + 9 + DOT_LAT;
  endfunction

endpackage
`default_nettype wire

// ===== sv/lam_delay.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lam_delay
// Fixed-length register line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module lam_delay #(
  parameter int W = 32,
  parameter int D = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] data_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] sr_q [D];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= data_i;
    for (int i = 1; i < D; i++) begin
      sr_q[i] <= sr_q[i-1];
    end
  end

  assign data_o = sr_q[D-1];

endmodule
`default_nettype wire

// ===== sv/lam_norm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lam_norm
// Pipelined 3-vector normalizer: magnitude alignment, square sum, digit-by-digit
// integer square root and three restoring dividers, one step per stage.
// ----------------------------------------------------------------------------
module lam_norm import lam_pkg::*; #(
  parameter int IW = 33,
  parameter int F  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [IW-1:0] vec_i [3],
  output norm_stat_t          stat_o,
  output logic signed [F+1:0] vec_o [3]
);

  localparam int AW  = F + 2;
  localparam int QW  = F + 1;
  localparam int NW  = MW + F + 1;
  localparam int XW  = IW + MW - 1;
  localparam int PSW = $clog2(IW);
  localparam int LAT = norm_lat(F);

  logic vp_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) begin
        vp_q[i] <= 1'b0;
      end
    end else begin
      vp_q[0] <= valid_i;
      for (int i = 1; i < LAT; i++) begin
        vp_q[i] <= vp_q[i-1];
      end
    end
  end

  // magnitudes
  logic [IW-1:0] m1_q [3];
  logic [2:0]    ng1_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      m1_q[k]  <= vec_i[k][IW-1] ? IW'(-vec_i[k]) : IW'(vec_i[k]);
      ng1_q[k] <= vec_i[k][IW-1];
    end
  end

  // leading one of the largest magnitude
  logic [IW-1:0]  orv;
  logic [PSW-1:0] pos_d;
  logic [IW-1:0]  m2_q [3];
  logic [2:0]     ng2_q;
  logic [PSW-1:0] pos2_q;
  logic           nz2_q;

  always_comb begin
    orv   = m1_q[0] | m1_q[1] | m1_q[2];
    pos_d = '0;
    for (int i = 0; i < IW; i++) begin
      if (orv[i]) begin
        pos_d = PSW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m2_q   <= m1_q;
    ng2_q  <= ng1_q;
    pos2_q <= pos_d;
    nz2_q  <= |orv;
  end

  // align leading one to the top of the window
  logic [XW-1:0] ext [3];
  logic [MW-1:0] m3_q [3];
  logic [2:0]    ng3_q;
  logic          nz3_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ext[k] = {m2_q[k], {(MW-1){1'b0}}} >> pos2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      m3_q[k] <= ext[k][MW-1:0];
    end
    ng3_q <= ng2_q;
    nz3_q <= nz2_q;
  end

  // squares
  logic [2*MW-1:0] sq4_q [3];
  logic [MW-1:0]   m4_q [3];
  logic [2:0]      ng4_q;
  logic            nz4_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq4_q[k] <= m3_q[k] * m3_q[k];
    end
    m4_q  <= m3_q;
    ng4_q <= ng3_q;
    nz4_q <= nz3_q;
  end

  // square root, two radicand bits per stage
  logic [SW-1:0] rs_q   [LW+1];
  logic [RW-1:0] rem_q  [LW+1];
  logic [LW-1:0] root_q [LW+1];
  logic [MW-1:0] rm_q   [LW+1][3];
  logic [2:0]    rng_q  [LW+1];
  logic          rnz_q  [LW+1];

  always_ff @(posedge clk_i) begin
    rs_q[0]   <= SW'(sq4_q[0]) + SW'(sq4_q[1]) + SW'(sq4_q[2]);
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    rm_q[0]   <= m4_q;
    rng_q[0]  <= ng4_q;
    rnz_q[0]  <= nz4_q;
  end

  for (genvar j = 0; j < LW; j++) begin : g_root
    localparam int K = LW - 1 - j;
    logic [RW-1:0] rt;
    logic [RW-1:0] tr;

    always_comb begin
      rt = {rem_q[j][RW-3:0], rs_q[j][2*K+1 -: 2]};
      tr = RW'({root_q[j], 2'b01});
    end

    always_ff @(posedge clk_i) begin
      rs_q[j+1]  <= rs_q[j];
      rm_q[j+1]  <= rm_q[j];
      rng_q[j+1] <= rng_q[j];
      rnz_q[j+1] <= rnz_q[j];
      if (rt >= tr) begin
        rem_q[j+1]  <= rt - tr;
        root_q[j+1] <= {root_q[j][LW-2:0], 1'b1};
      end else begin
        rem_q[j+1]  <= rt;
        root_q[j+1] <= {root_q[j][LW-2:0], 1'b0};
      end
    end
  end

  // rounded division by the length
  logic [LW-1:0] dr_q  [QW+1][3];
  logic [QW-1:0] dn_q  [QW+1][3];
  logic [QW-1:0] dq_q  [QW+1][3];
  logic [LW-1:0] dl_q  [QW+1];
  logic [2:0]    dng_q [QW+1];
  logic          dnz_q [QW+1];
  logic [NW-1:0] num [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = NW'({rm_q[LW][k], {F{1'b0}}}) + NW'(root_q[LW] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      dr_q[0][k] <= LW'(num[k][NW-1:QW]);
      dn_q[0][k] <= num[k][QW-1:0];
      dq_q[0][k] <= '0;
    end
    dl_q[0]  <= root_q[LW];
    dng_q[0] <= rng_q[LW];
    dnz_q[0] <= rnz_q[LW];
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [LW:0] tv [3];

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        tv[k] = {dr_q[i][k], dn_q[i][k][QW-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      dl_q[i+1]  <= dl_q[i];
      dng_q[i+1] <= dng_q[i];
      dnz_q[i+1] <= dnz_q[i];
      for (int k = 0; k < 3; k++) begin
        dn_q[i+1][k] <= {dn_q[i][k][QW-2:0], 1'b0};
        if (tv[k] >= {1'b0, dl_q[i]}) begin
          dr_q[i+1][k] <= LW'(tv[k] - {1'b0, dl_q[i]});
          dq_q[i+1][k] <= {dq_q[i][k][QW-2:0], 1'b1};
        end else begin
          dr_q[i+1][k] <= LW'(tv[k]);
          dq_q[i+1][k] <= {dq_q[i][k][QW-2:0], 1'b0};
        end
      end
    end
  end

  // sign
  logic signed [AW-1:0] qa [3];
  logic signed [AW-1:0] vo_q [3];
  logic                 nzo_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qa[k] = AW'(dq_q[QW][k]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (!dnz_q[QW]) begin
        vo_q[k] <= '0;
      end else begin
        vo_q[k] <= dng_q[QW][k] ? -qa[k] : qa[k];
      end
    end
    nzo_q <= dnz_q[QW];
  end

  assign vec_o        = vo_q;
  assign stat_o.valid = vp_q[LAT-1];
  assign stat_o.nz    = nzo_q;

endmodule
`default_nettype wire

// ===== sv/lam_dot.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lam_dot
// Negated dot product of an axis with the eye point, rounded and saturated.
// ----------------------------------------------------------------------------
module lam_dot import lam_pkg::*; #(
  parameter int F = 16
) (
  input  logic                clk_i,
  input  logic signed [F+1:0] a_i [3],
  input  logic signed [31:0]  e_i [3],
  output logic signed [31:0]  d_o
);

  localparam int AW  = F + 2;
  localparam int PW  = AW + 32;
  localparam int SW2 = PW + 2;
  localparam logic [SW2-1:0] HALF = SW2'(1) << (F - 1);
  localparam logic [SW2-1:0] POS_LIM = SW2'(I32_MAX);
  localparam logic [SW2-1:0] NEG_LIM = SW2'(1) << 31;

  logic signed [PW-1:0]  p_q [3];
  logic signed [SW2-1:0] sum_q;
  logic [SW2-1:0]        mag;
  logic [SW2-1:0]        r3_q;
  logic                  neg3_q;
  logic signed [31:0]    d_q;

  always_comb begin
    mag = sum_q[SW2-1] ? SW2'(-sum_q) : SW2'(sum_q);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      p_q[k] <= a_i[k] * e_i[k];
    end
    sum_q  <= SW2'(p_q[0]) + SW2'(p_q[1]) + SW2'(p_q[2]);
    neg3_q <= sum_q[SW2-1];
    r3_q   <= (mag + HALF) >> F;
    if (neg3_q) begin
      d_q <= (r3_q > POS_LIM) ? I32_MAX : 32'(r3_q);
    end else begin
      d_q <= (r3_q > NEG_LIM) ? I32_MIN : 32'(-r3_q);
    end
  end

  assign d_o = d_q;

endmodule
`default_nettype wire

// ===== sv/look_at_view_matrix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Left-handed look-at camera axes and translation in signed fixed point.
// ----------------------------------------------------------------------------
// A transaction is taken on every cycle that start_i is high; busy_o never
// rises, so one camera per clock goes in and one result per clock comes out.
// Each result appears on the output ports for a single cycle with done_o high.
// The receiver cannot stall and must take every result in the cycle it is
// shown. Latency is set by the two normalizers in series, each with a 31-stage
// square root and a FRAC_BITS+1 stage divider.
module look_at_view_matrix import lam_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] eye_x_i,
  input  logic signed [31:0] eye_y_i,
  input  logic signed [31:0] eye_z_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic signed [31:0] up_x_i,
  input  logic signed [31:0] up_y_i,
  input  logic signed [31:0] up_z_i,
  output logic               done_o,
  output logic signed [17:0] right_x_o,
  output logic signed [17:0] right_y_o,
  output logic signed [17:0] right_z_o,
  output logic signed [17:0] upward_x_o,
  output logic signed [17:0] upward_y_o,
  output logic signed [17:0] upward_z_o,
  output logic signed [17:0] forward_x_o,
  output logic signed [17:0] forward_y_o,
  output logic signed [17:0] forward_z_o,
  output logic signed [31:0] shift_right_o,
  output logic signed [31:0] shift_up_o,
  output logic signed [31:0] shift_forward_o
);

  localparam int AW  = FRAC_BITS + 2;
  localparam int LAT = norm_lat(FRAC_BITS);
  localparam int PW1 = 32 + AW;
  localparam int CW1 = 33 + AW;
  localparam int PW2 = 2 * AW;
  localparam int CW2 = 2 * AW + 1;
  localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;
  localparam logic [CW2-1:0] ONE_W  = CW2'(1) << FRAC_BITS;
  localparam logic [CW2-1:0] HALF_W = CW2'(1) << (FRAC_BITS - 1);

  assign busy_o = 1'b0;

  logic v_a_q, v_c_q, v_d_q, v_e_q, v_f_q, v_g_q, v_h_q, v_i_q, v_b_q;
  logic vd_q [DOT_LAT];
  norm_stat_t st1, st2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
      v_f_q <= 1'b0;
      v_g_q <= 1'b0;
      v_h_q <= 1'b0;
      v_i_q <= 1'b0;
      for (int i = 0; i < DOT_LAT; i++) begin
        vd_q[i] <= 1'b0;
      end
    end else begin
      v_a_q <= start_i && !busy_o;
      v_b_q <= v_a_q;
      v_c_q <= st1.valid;
      v_d_q <= v_c_q;
      v_e_q <= st2.valid;
      v_f_q <= v_e_q;
      v_g_q <= v_f_q;
      v_h_q <= v_g_q;
      v_i_q <= v_h_q;
      vd_q[0] <= v_i_q;
      for (int i = 1; i < DOT_LAT; i++) begin
        vd_q[i] <= vd_q[i-1];
      end
    end
  end

  // input registers and view direction
  logic signed [31:0] eye_a_q [3];
  logic signed [31:0] tgt_a_q [3];
  logic signed [31:0] up_a_q  [3];
  logic signed [32:0] d_b_q   [3];
  logic signed [31:0] eye_b_q [3];
  logic signed [31:0] up_b_q  [3];

  always_ff @(posedge clk_i) begin
    eye_a_q <= '{eye_x_i, eye_y_i, eye_z_i};
    tgt_a_q <= '{target_x_i, target_y_i, target_z_i};
    up_a_q  <= '{up_x_i, up_y_i, up_z_i};
    for (int k = 0; k < 3; k++) begin
      d_b_q[k] <= 33'(tgt_a_q[k]) - 33'(eye_a_q[k]);
    end
    eye_b_q <= eye_a_q;
    up_b_q  <= up_a_q;
  end

  logic signed [AW-1:0] fwd1 [3];

  lam_norm #(
    .IW (33),
    .F  (FRAC_BITS)
  ) u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_b_q),
    .vec_i   (d_b_q),
    .stat_o  (st1),
    .vec_o   (fwd1)
  );

  logic [191:0]       dl1;
  logic signed [31:0] eye1 [3];
  logic signed [31:0] up1  [3];

  lam_delay #(
    .W (192),
    .D (LAT)
  ) u_dly_eu (
    .clk_i  (clk_i),
    .data_i ({eye_b_q[0], eye_b_q[1], eye_b_q[2], up_b_q[0], up_b_q[1], up_b_q[2]}),
    .data_o (dl1)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      eye1[k] = dl1[32*(5-k) +: 32];
      up1[k]  = dl1[32*(2-k) +: 32];
    end
  end

  // up hint cross forward
  logic signed [PW1-1:0] pc_q [6];
  logic signed [AW-1:0]  fwd_c_q [3];
  logic signed [31:0]    eye_c_q [3];
  logic signed [CW1-1:0] t_d_q [3];
  logic signed [AW-1:0]  fwd_d_q [3];
  logic signed [31:0]    eye_d_q [3];

  always_ff @(posedge clk_i) begin
    pc_q[0] <= up1[1] * fwd1[2];
    pc_q[1] <= up1[2] * fwd1[1];
    pc_q[2] <= up1[2] * fwd1[0];
    pc_q[3] <= up1[0] * fwd1[2];
    pc_q[4] <= up1[0] * fwd1[1];
    pc_q[5] <= up1[1] * fwd1[0];
    fwd_c_q <= fwd1;
    eye_c_q <= eye1;
    for (int k = 0; k < 3; k++) begin
      t_d_q[k] <= CW1'(pc_q[2*k]) - CW1'(pc_q[2*k+1]);
    end
    fwd_d_q <= fwd_c_q;
    eye_d_q <= eye_c_q;
  end

  logic signed [AW-1:0] rgt2 [3];

  lam_norm #(
    .IW (CW1),
    .F  (FRAC_BITS)
  ) u_norm_rgt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_d_q),
    .vec_i   (t_d_q),
    .stat_o  (st2),
    .vec_o   (rgt2)
  );

  logic [3*AW+95:0]     dl2;
  logic signed [AW-1:0] fwd2 [3];
  logic signed [31:0]   eye2 [3];

  lam_delay #(
    .W (3*AW + 96),
    .D (LAT)
  ) u_dly_fe (
    .clk_i  (clk_i),
    .data_i ({fwd_d_q[0], fwd_d_q[1], fwd_d_q[2], eye_d_q[0], eye_d_q[1], eye_d_q[2]}),
    .data_o (dl2)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fwd2[k] = dl2[96 + AW*(2-k) +: AW];
      eye2[k] = dl2[32*(2-k) +: 32];
    end
  end

  // right axis fallback, then forward cross right, rounded and clamped, with an up fallback
  logic signed [AW-1:0]  rgt_e_q [3], rgt_f_q [3], rgt_g_q [3], rgt_h_q [3], rgt_i_q [3];
  logic signed [AW-1:0]  fwd_e_q [3], fwd_f_q [3], fwd_g_q [3], fwd_h_q [3], fwd_i_q [3];
  logic signed [31:0]    eye_e_q [3], eye_f_q [3], eye_g_q [3], eye_h_q [3], eye_i_q [3];
  logic signed [PW2-1:0] pu_q [6];
  logic signed [CW2-1:0] ud_g_q [3];
  logic [CW2-1:0]        umag [3];
  logic [CW2-1:0]        ur_h_q [3];
  logic [2:0]            ung_h_q;
  logic signed [AW-1:0]  uc [3];
  logic signed [AW-1:0]  upw_i_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      umag[k] = ud_g_q[k][CW2-1] ? CW2'(-ud_g_q[k]) : CW2'(ud_g_q[k]);
      if (ur_h_q[k] > ONE_W) begin
        uc[k] = ung_h_q[k] ? -ONE : ONE;
      end else begin
        uc[k] = ung_h_q[k] ? -AW'(ur_h_q[k]) : AW'(ur_h_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st2.nz) begin
      rgt_e_q <= rgt2;
    end else begin
      rgt_e_q <= '{ONE, '0, '0};
    end
    fwd_e_q <= fwd2;
    eye_e_q <= eye2;

    pu_q[0] <= fwd_e_q[1] * rgt_e_q[2];
    pu_q[1] <= fwd_e_q[2] * rgt_e_q[1];
    pu_q[2] <= fwd_e_q[2] * rgt_e_q[0];
    pu_q[3] <= fwd_e_q[0] * rgt_e_q[2];
    pu_q[4] <= fwd_e_q[0] * rgt_e_q[1];
    pu_q[5] <= fwd_e_q[1] * rgt_e_q[0];
    rgt_f_q <= rgt_e_q;
    fwd_f_q <= fwd_e_q;
    eye_f_q <= eye_e_q;

    for (int k = 0; k < 3; k++) begin
      ud_g_q[k]  <= CW2'(pu_q[2*k]) - CW2'(pu_q[2*k+1]);
      ung_h_q[k] <= ud_g_q[k][CW2-1];
      ur_h_q[k]  <= (umag[k] + HALF_W) >> FRAC_BITS;
    end
    rgt_g_q <= rgt_f_q;
    fwd_g_q <= fwd_f_q;
    eye_g_q <= eye_f_q;
    rgt_h_q <= rgt_g_q;
    fwd_h_q <= fwd_g_q;
    eye_h_q <= eye_g_q;

    if (ur_h_q[0] == '0 && ur_h_q[1] == '0 && ur_h_q[2] == '0) begin
      upw_i_q <= '{'0, ONE, '0};
    end else begin
      upw_i_q <= uc;
    end
    rgt_i_q <= rgt_h_q;
    fwd_i_q <= fwd_h_q;
    eye_i_q <= eye_h_q;
  end

  // translation terms
  lam_dot #(.F(FRAC_BITS)) u_dot_rgt (
    .clk_i (clk_i),
    .a_i   (rgt_i_q),
    .e_i   (eye_i_q),
    .d_o   (shift_right_o)
  );

  lam_dot #(.F(FRAC_BITS)) u_dot_up (
    .clk_i (clk_i),
    .a_i   (upw_i_q),
    .e_i   (eye_i_q),
    .d_o   (shift_up_o)
  );

  lam_dot #(.F(FRAC_BITS)) u_dot_fwd (
    .clk_i (clk_i),
    .a_i   (fwd_i_q),
    .e_i   (eye_i_q),
    .d_o   (shift_forward_o)
  );

  logic [9*AW-1:0]      dl3;
  logic signed [AW-1:0] ax [9];

  lam_delay #(
    .W (9*AW),
    .D (DOT_LAT)
  ) u_dly_ax (
    .clk_i  (clk_i),
    .data_i ({rgt_i_q[0], rgt_i_q[1], rgt_i_q[2], upw_i_q[0], upw_i_q[1], upw_i_q[2],
              fwd_i_q[0], fwd_i_q[1], fwd_i_q[2]}),
    .data_o (dl3)
  );

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      ax[k] = dl3[AW*(8-k) +: AW];
    end
  end

  assign right_x_o   = 18'(ax[0]);
  assign right_y_o   = 18'(ax[1]);
  assign right_z_o   = 18'(ax[2]);
  assign upward_x_o  = 18'(ax[3]);
  assign upward_y_o  = 18'(ax[4]);
  assign upward_z_o  = 18'(ax[5]);
  assign forward_x_o = 18'(ax[6]);
  assign forward_y_o = 18'(ax[7]);
  assign forward_z_o = 18'(ax[8]);
  assign done_o      = vd_q[DOT_LAT-1];

endmodule
`default_nettype wire

// ===== sv/lam_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lam_checker
// Port-level checks: fixed latency from start to done, and busy never raised.
// ----------------------------------------------------------------------------
module lam_checker import lam_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_i,
  input logic done_i
);

  localparam int TOT = total_lat(FRAC_BITS);

  a_no_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_i)
    else $error("busy raised");

  a_start_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |-> ##TOT done_i)
    else $error("transaction result missing");

  a_done_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(start_i && !busy_i, TOT))
    else $error("result without transaction");

endmodule

bind look_at_view_matrix lam_checker #(.FRAC_BITS(FRAC_BITS)) u_lam_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_i  (busy_o),
  .done_i  (done_o)
);
`default_nettype wire

// ===== verif/look_at_view_matrix_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_tb
// Drives camera transactions (eye, target, up hint) into the look-at block.
// A built-in fixed-point camera model computes the expected axes and
// translation terms, and every done_o strobe is checked against the oldest
// pending camera in order. The run covers corner cameras, full-range noise,
// random scenes and random start gaps, including full drains.
// ----------------------------------------------------------------------------
module look_at_view_matrix_tb import lam_pkg::*;;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 <<< FB;

  typedef longint vec3_t [3];

  typedef struct {
    logic [17:0] axis [9];
    logic [31:0] shift [3];
  } camera_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [31:0] eye_x_i = '0, eye_y_i = '0, eye_z_i = '0;
  logic signed [31:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic signed [31:0] up_x_i = '0, up_y_i = '0, up_z_i = '0;
  logic done_o;
  logic signed [17:0] right_x_o, right_y_o, right_z_o;
  logic signed [17:0] upward_x_o, upward_y_o, upward_z_o;
  logic signed [17:0] forward_x_o, forward_y_o, forward_z_o;
  logic signed [31:0] shift_right_o, shift_up_o, shift_forward_o;

  camera_t pending_cameras [$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  bit no_gaps = 1'b0;

  look_at_view_matrix #(.FRAC_BITS(FB)) dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] root_floor(input logic [63:0] s);
    logic [63:0] res, b;
    res = '0;
    b = 64'h1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint mag(input longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic bit unit_vec(input vec3_t v, output vec3_t o);
    logic [63:0] m [3];
    logic [63:0] mx, s, len, q;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      o = '{0, 0, 0};
      return 1'b0;
    end
    while (mx >= (64'h1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'h1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) s += m[i] * m[i];
    len = root_floor(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint round_q(input longint x);
    longint r;
    r = (mag(x) + (64'sd1 <<< (FB - 1))) >>> FB;
    return x < 0 ? -r : r;
  endfunction

  function automatic void cross_prod(input vec3_t a, input vec3_t b, output vec3_t o);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic logic [31:0] neg_dot(input vec3_t a, input vec3_t e);
    longint d;
    d = -round_q(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
    if (d > longint'(I32_MAX)) d = I32_MAX;
    if (d < longint'(I32_MIN)) d = I32_MIN;
    return d[31:0];
  endfunction

  function automatic camera_t predict_camera(input vec3_t eye, input vec3_t tgt,
                                             input vec3_t up);
    camera_t c;
    vec3_t dir, fwd, rgt, upw, t;
    longint k;
    for (int i = 0; i < 3; i++) dir[i] = tgt[i] - eye[i];
    void'(unit_vec(dir, fwd));
    cross_prod(up, fwd, t);
    if (!unit_vec(t, rgt)) rgt = '{ONE, 0, 0};
    cross_prod(fwd, rgt, t);
    for (int i = 0; i < 3; i++) begin
      k = round_q(t[i]);
      if (k > ONE) k = ONE;
      if (k < -ONE) k = -ONE;
      upw[i] = k;
    end
    if (upw[0] == 0 && upw[1] == 0 && upw[2] == 0) upw[1] = ONE;
    for (int i = 0; i < 3; i++) begin
      c.axis[i] = rgt[i][17:0];
      c.axis[3 + i] = upw[i][17:0];
      c.axis[6 + i] = fwd[i][17:0];
    end
    c.shift[0] = neg_dot(rgt, eye);
    c.shift[1] = neg_dot(upw, eye);
    c.shift[2] = neg_dot(fwd, eye);
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_camera(input logic signed [31:0] v [9]);
    vec3_t eye, tgt, up;
    eye_x_i <= v[0]; eye_y_i <= v[1]; eye_z_i <= v[2];
    target_x_i <= v[3]; target_y_i <= v[4]; target_z_i <= v[5];
    up_x_i <= v[6]; up_y_i <= v[7]; up_z_i <= v[8];
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    for (int i = 0; i < 3; i++) begin
      eye[i] = v[i];
      tgt[i] = v[3 + i];
      up[i] = v[6 + i];
    end
    pending_cameras.push_back(predict_camera(eye, tgt, up));
    sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    int n, r;
    r = $urandom_range(99);
    if (no_gaps || r < 65) return;
    n = r < 94 ? $urandom_range(1, 3) : $urandom_range(10, 40);
    start_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic send_and_gap(input logic signed [31:0] v [9]);
    send_camera(v);
    idle_gap();
  endtask

  task automatic drain_all();
    start_i <= 1'b0;
    while (pending_cameras.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    logic [17:0] got_axis [9];
    logic [31:0] got_shift [3];
    camera_t exp_c;
    string axis_names [9];
    string shift_names [3];
    axis_names = '{"right_x", "right_y", "right_z", "upward_x", "upward_y",
                   "upward_z", "forward_x", "forward_y", "forward_z"};
    shift_names = '{"shift_right", "shift_up", "shift_forward"};
    if (rst_ni && done_o) begin
      got_axis = '{right_x_o, right_y_o, right_z_o, upward_x_o, upward_y_o,
                   upward_z_o, forward_x_o, forward_y_o, forward_z_o};
      got_shift = '{shift_right_o, shift_up_o, shift_forward_o};
      if (pending_cameras.size() == 0) begin
        $error("result transaction with no camera pending");
        errors++;
      end else begin
        exp_c = pending_cameras.pop_front();
        checked++;
        for (int i = 0; i < 9; i++)
          if (got_axis[i] !== exp_c.axis[i]) begin
            $error("%s expected %0d actual %0d", axis_names[i],
                   $signed(exp_c.axis[i]), $signed(got_axis[i]));
            errors++;
          end
        for (int i = 0; i < 3; i++)
          if (got_shift[i] !== exp_c.shift[i]) begin
            $error("%s expected %0d actual %0d", shift_names[i],
                   $signed(exp_c.shift[i]), $signed(got_shift[i]));
            errors++;
          end
      end
    end
  end

  task automatic test_corner_cameras();
    logic signed [31:0] mx, mn, o;
    mx = I32_MAX;
    mn = I32_MIN;
    o = 32'sh10000;
    no_gaps = 1'b1;
    // all zero, eye equals target
    send_camera('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_camera('{o, 2 * o, -o, o, 2 * o, -o, 0, o, 0});
    // plain cameras along each axis
    send_camera('{0, 0, 0, 0, 0, o, 0, o, 0});
    send_camera('{0, 0, 0, o, 0, 0, 0, o, 0});
    send_camera('{0, 0, 0, 0, -o, 0, 0, 0, o});
    // up hint parallel to forward, and zero
    send_camera('{0, 0, 0, 0, 0, o, 0, 0, 5 * o});
    send_camera('{0, 0, 0, 0, 3 * o, 0, 0, -o, 0});
    send_camera('{o, o, o, 4 * o, 0, 2 * o, 0, 0, 0});
    // field extremes and saturating translation
    send_camera('{mx, mx, mx, mn, mn, mn, mx, mn, mx});
    send_camera('{mn, mn, mn, mx, mx, mx, mn, mx, mn});
    send_camera('{mn, 0, 0, mx, 0, 0, 0, mx, 0});
    send_camera('{mx, mn, mx, mx, mn, mn, mn, mn, mn});
    send_camera('{mn, mx, mn, 0, 0, 0, mx, mx, mx});
    send_camera('{-1, 1, -1, 1, -1, 1, -1, 1, -1});
    send_camera('{0, 0, 0, 1, 1, 1, 1, 0, 0});
    send_camera('{mx, mx, mx, mx - 1, mx, mx, 0, 1, 0});
    no_gaps = 1'b0;
    drain_all();
  endtask

  task automatic test_full_range_noise(input int n);
    logic signed [31:0] v [9];
    repeat (n) begin
      for (int i = 0; i < 9; i++) v[i] = $urandom;
      send_and_gap(v);
    end
  endtask

  task automatic test_random_scenes(input int n);
    logic signed [31:0] v [9];
    int span;
    repeat (n) begin
      span = ($urandom_range(3) == 0) ? 32'h7fff_ffff : 32'h0400_0000;
      for (int i = 0; i < 6; i++) v[i] = $signed($urandom_range(2 * span)) - span;
      // mostly a y-ish up hint, sometimes exactly along forward or with eye equal to target
      v[6] = $signed($urandom_range(32'h2_0000)) - 32'sh1_0000;
      v[7] = 32'sh1_0000 + $signed($urandom_range(32'h4000)) - 32'sh2000;
      v[8] = $signed($urandom_range(32'h2_0000)) - 32'sh1_0000;
      case ($urandom_range(7))
        0: for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i] - v[i];
        1: for (int i = 0; i < 3; i++) v[3 + i] = v[i];
        2: no_gaps = ~no_gaps;
        default: ;
      endcase
      send_and_gap(v);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_pause_until_drained();
    logic signed [31:0] v [9];
    repeat (20) begin
      for (int i = 0; i < 9; i++) v[i] = $urandom;
      send_camera(v);
    end
    drain_all();
    test_full_range_noise(20);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_corner_cameras();
    test_full_range_noise(600);
    test_pause_until_drained();
    test_random_scenes(1300);
    start_i <= 1'b0;
    while (pending_cameras.size() != 0) @(negedge clk_i);
    repeat (total_lat(FB) + 10) @(negedge clk_i);
    $display("sent %0d cameras, checked %0d results", sent, checked);
    $display("corner cameras, full-range noise, scenes and a full drain covered");
    if (errors == 0 && pending_cameras.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
